FILE: hdl/apt_pkg.sv
// Package for the animation progress tracker: formats, command codes and sequencer states.
`timescale 1ns / 1ps

package apt_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// iteration position: signed, 48 bits
	localparam int POS_W = 48;
	// quotient bits produced by the divider; larger quotients saturate
	localparam int Q_W = 48;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [31:0] DURATION_RST  = 32'd0;
	localparam logic [31:0] DELAY_RST     = 32'd0;
	localparam logic [31:0] COUNT_RST     = 32'd65536;
	localparam logic [15:0] SLOWDOWN_RST  = 16'd256;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_FINISH  = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_SKIP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DURATION = 2'd0,
		REG_DELAY    = 2'd1,
		REG_COUNT    = 2'd2,
		REG_SLOWDOWN = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_DURING = 2'd1,
		PH_AFTER  = 2'd2
	} phase_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MUL   = 10'b00_0000_0010,
		ST_DINIT = 10'b00_0000_0100,
		ST_DIV   = 10'b00_0000_1000,
		ST_APPLY = 10'b00_0001_0000,
		ST_EVAL  = 10'b00_0010_0000,
		ST_PROG  = 10'b00_0100_0000,
		ST_SQ    = 10'b00_1000_0000,
		ST_CUBE  = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

endpackage

FILE: hdl/animation_progress_tracker.sv
// Animation progress tracker: frame timestamps in, phase, iteration, progress and ease out.
`timescale 1ns / 1ps

// Each input transaction carries a command (start, finish, advance, skip) in tuser and a
// frame timestamp in microseconds plus a reverse flag in tdata; each one yields exactly one
// output transaction describing the tracker after the command. A start latches duration and
// iteration count and places the position at minus delay over duration; an advance adds the
// elapsed time scaled by slowdown and duration; the first frame after a start and every skip
// only record the time; a timestamp earlier than the last is dropped and flagged. One item is
// handled at a time and s_axis_tready is high only while the sequencer is idle. Start and a
// real advance run a restoring divider at one quotient bit per cycle over 48 bits; an advance
// first takes an extra step for the slowdown times duration product, and a quotient that
// saturates skips the bit loop. Finish, skip, a stopped tracker, a backward frame and a
// frame that only records its time bypass the divider and go straight to evaluation. A
// single 34x17 multiplier is shared by the divisor product
// and the two steps of the ease-out cube. The result sits in an output register, so the next
// command is taken while the previous result still waits on m_axis_tready; a new result that
// finds that register still full holds the sequencer until m_axis_tready frees it.
// Configuration writes are meant for idle periods only.
module animation_progress_tracker
	import apt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // timestamp_us[63:0], reversed[64], zero pad
	input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata    // phase[1:0], iteration_q16[33:2], cycle_index[49:34],
	                                    // progress_q16[66:50], eased_q16[83:67],
	                                    // went_backwards[84], zero pad
);

	// numerator shift of the advance step, numerator width
	localparam int SHIFT  = 8 + FRAC_BITS;
	localparam int NUM_W  = 64 + SHIFT;
	localparam int CNT_W  = $clog2(Q_W);
	localparam int SH_R   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SH_L   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	// configuration registers
	logic [31:0] duration_q;
	logic [31:0] delay_q;
	logic [31:0] count_q;
	logic [15:0] slowdown_q;

	// tracker state
	logic                    running_q;
	logic [63:0]             last_time_q;
	logic signed [POS_W-1:0] pos_q;
	logic [31:0]             lat_duration_q;
	logic [31:0]             lat_count_q;

	state_t state_q;

	// per-item working registers
	cmd_t              cmd_q;
	logic              rev_q;
	logic              back_q;
	logic [63:0]       ft_q;
	logic [NUM_W-1:0]  num_q;
	logic [Q_W-1:0]    den_q;
	logic [Q_W-1:0]    rem_q;
	logic [Q_W-1:0]    quo_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	phase_t            phase_q;
	logic [31:0]       it_q;
	logic [15:0]       cyc_q;
	logic [16:0]       prog_q;
	logic [16:0]       m_q;
	logic [33:0]       m2_q;
	logic [48:0]       cube_q;

	logic [87:0] out_data_q;
	logic        out_valid_q;

	// input fields
	cmd_t        in_cmd;
	logic [63:0] in_ft;
	logic        in_rev;
	logic        in_acc;

	assign in_cmd = cmd_t'(s_axis_tuser);
	assign in_ft  = s_axis_tdata[63:0];
	assign in_rev = s_axis_tdata[64];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// timestamp difference; the borrow marks a frame that went backwards
	logic [64:0] dt_full;
	assign dt_full = {1'b0, in_ft} - {1'b0, last_time_q};

	// start offset operands
	logic        dly_neg;
	logic [31:0] dly_mag;
	logic [31:0] dur_max;
	logic [31:0] lat_dur_max;
	logic [15:0] sd_max;

	assign dly_neg     = delay_q[31];
	assign dly_mag     = dly_neg ? (32'd0 - delay_q) : delay_q;
	assign dur_max     = (duration_q == 32'd0) ? 32'd1 : duration_q;
	assign lat_dur_max = (lat_duration_q == 32'd0) ? 32'd1 : lat_duration_q;
	assign sd_max      = (slowdown_q == 16'd0) ? 16'd1 : slowdown_q;

	// shared multiplier
	logic [33:0] mul_a;
	logic [16:0] mul_b;
	logic [50:0] prod;

	always_comb begin
		unique case (state_q)
			ST_MUL: begin
				mul_a = {2'b00, lat_dur_max};
				mul_b = {1'b0, sd_max};
			end
			ST_SQ: begin
				mul_a = {17'd0, m_q};
				mul_b = m_q;
			end
			ST_CUBE: begin
				mul_a = m2_q;
				mul_b = m_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 51'(mul_a) * 51'(mul_b);

	// divider step: bring down the next numerator bit, subtract when it fits
	logic [Q_W-1:0] num_hi;
	logic [Q_W:0]   rem_sh;
	logic           rem_fit;

	assign num_hi  = Q_W'(num_q[NUM_W-1:Q_W]);
	assign rem_sh  = {rem_q, num_q[Q_W-1]};
	assign rem_fit = rem_sh >= {1'b0, den_q};

	// position update
	logic                    q_big;
	logic signed [POS_W-1:0] start_pos;
	logic [Q_W:0]            delta;
	logic signed [POS_W+1:0] pos_sum;
	logic signed [POS_W-1:0] adv_pos;

	assign q_big     = ovf_q || quo_q[Q_W-1];
	assign start_pos = cmd_q == CMD_START && dly_neg
		? (q_big ? POS_MAX : POS_W'(quo_q))
		: (q_big ? POS_MIN : POS_W'(0 - quo_q));
	assign delta     = ovf_q ? {1'b1, {Q_W{1'b0}}} : {1'b0, quo_q};
	assign pos_sum   = {{2{pos_q[POS_W-1]}}, pos_q} + $signed({1'b0, delta});
	assign adv_pos   = (!pos_sum[POS_W+1] && pos_sum[POS_W:POS_W-1] != 2'b00)
		? POS_MAX : pos_sum[POS_W-1:0];

	// phase and clamped iteration
	logic [63:0] pos_cmp;
	logic [63:0] cnt_cmp;
	logic [63:0] pos_ext;
	logic [63:0] it_full;

	assign pos_cmp = {pos_q, 16'd0};
	assign cnt_cmp = {32'd0, lat_count_q} << FRAC_BITS;
	assign pos_ext = {16'd0, pos_q};
	assign it_full = (pos_ext >> SH_R) << SH_L;

	// cycle index and progress
	logic [31:0] it_m1;
	logic [16:0] prog_raw;

	assign it_m1    = it_q - 32'd1;
	assign prog_raw = (it_q == 32'd0) ? 17'd0 : ({1'b0, it_m1[15:0]} + 17'd1);

	// rounded cube for the ease out
	logic [48:0] cube_rnd;
	logic [16:0] eased;
	logic        out_load;

	assign cube_rnd = cube_q + 49'h0_8000_0000;
	assign eased    = ONE_Q16 - cube_rnd[48:32];
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q <= DURATION_RST;
			delay_q    <= DELAY_RST;
			count_q    <= COUNT_RST;
			slowdown_q <= SLOWDOWN_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DURATION: duration_q <= cfg_data;
				REG_DELAY:    delay_q    <= cfg_data;
				REG_COUNT:    count_q    <= cfg_data;
				REG_SLOWDOWN: slowdown_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			running_q      <= 1'b0;
			last_time_q    <= 64'd0;
			pos_q          <= '0;
			lat_duration_q <= 32'd0;
			lat_count_q    <= 32'd0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_cmd)
							CMD_START: begin
								running_q      <= 1'b1;
								last_time_q    <= 64'd0;
								lat_duration_q <= duration_q;
								lat_count_q    <= count_q;
								state_q        <= ST_DINIT;
							end
							CMD_FINISH: begin
								running_q <= 1'b0;
								state_q   <= ST_EVAL;
							end
							default: begin
								// advance or skip
								if (!running_q) begin
									state_q <= ST_EVAL;
								end else if (in_cmd == CMD_SKIP || last_time_q == 64'd0) begin
									last_time_q <= in_ft;
									state_q     <= ST_EVAL;
								end else if (dt_full[64]) begin
									state_q <= ST_EVAL;
								end else begin
									state_q <= ST_MUL;
								end
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					cnt_q <= CNT_W'(Q_W - 1);
					// a quotient of 2^48 or more saturates; skip the bit loop
					state_q <= (num_hi >= den_q) ? ST_APPLY : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_APPLY: begin
					if (cmd_q == CMD_START) begin
						pos_q <= start_pos;
					end else begin
						pos_q       <= adv_pos;
						last_time_q <= ft_q;
					end
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_PROG;
				end
				ST_PROG: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_CUBE;
				end
				ST_CUBE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd_q  <= in_cmd;
					rev_q  <= in_rev;
					ft_q   <= in_ft;
					back_q <= (in_cmd == CMD_ADVANCE) && running_q &&
						(last_time_q != 64'd0) && dt_full[64];
					if (in_cmd == CMD_START) begin
						num_q <= {{(NUM_W-32){1'b0}}, dly_mag} << FRAC_BITS;
						den_q <= Q_W'(dur_max);
					end else begin
						num_q <= {dt_full[63:0], {SHIFT{1'b0}}};
					end
				end
			end
			ST_MUL: begin
				den_q <= prod[Q_W-1:0];
			end
			ST_DINIT: begin
				ovf_q <= num_hi >= den_q;
				rem_q <= num_hi;
				quo_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_fit ? (rem_sh[Q_W-1:0] - den_q) : rem_sh[Q_W-1:0];
				quo_q <= {quo_q[Q_W-2:0], rem_fit};
				num_q <= num_q << 1;
			end
			ST_EVAL: begin
				if (!running_q) begin
					phase_q <= PH_AFTER;
					it_q    <= 32'(ONE_Q16);
				end else if (pos_q[POS_W-1]) begin
					phase_q <= PH_BEFORE;
					it_q    <= 32'd0;
				end else if (pos_cmp > cnt_cmp) begin
					phase_q <= PH_AFTER;
					it_q    <= lat_count_q;
				end else begin
					phase_q <= PH_DURING;
					it_q    <= it_full[31:0];
				end
			end
			ST_PROG: begin
				cyc_q  <= (it_q == 32'd0) ? 16'd0 : it_m1[31:16];
				prog_q <= rev_q ? (ONE_Q16 - prog_raw) : prog_raw;
				m_q    <= rev_q ? prog_raw : (ONE_Q16 - prog_raw);
			end
			ST_SQ: begin
				m2_q <= prod[33:0];
			end
			ST_CUBE: begin
				cube_q <= prod[48:0];
			end
			ST_DONE: begin
				if (out_load) begin
					out_data_q <= {3'd0, back_q, eased, prog_q, cyc_q, it_q, phase_q};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
